[src/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_PUSH_LEFT  = 2'd0;
	localparam kind_t KIND_PUSH_RIGHT = 2'd1;
	localparam kind_t KIND_POP_LEFT   = 2'd2;
	localparam kind_t KIND_POP_RIGHT  = 2'd3;

	localparam status_t STAT_DONE      = 2'd0;
	localparam status_t STAT_OVERFLOW  = 2'd1;
	localparam status_t STAT_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

[src/circular_deque_unit.sv]
`default_nettype none

// Channel   Direction  Signals                                        Transaction
// command   in         start, kind, push_value                        start && !busy
// result    out        done, status, removed_value, is_empty,         done (one cycle)
//                      left_end_value, right_end_value
//
// A push, a refused operation or a pop that empties the queue reports its result
// in the cycle after acceptance, and the next command may be accepted at once.
// A pop that leaves entries behind passes through ST_FETCH: the new end value comes from
// the registered read of the ring memory, and busy stays high while it is fetched.
// Reset clears the indices and marks the queue empty; the ring memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.

module circular_deque_unit #(
	parameter int RING_DEPTH  = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire cdq_pkg::kind_t         kind,
	input  wire logic signed [31:0]     push_value,
	output logic                        done,
	output cdq_pkg::status_t            status,
	output logic signed [31:0]          removed_value,
	output logic                        is_empty,
	output logic signed [31:0]          left_end_value,
	output logic signed [31:0]          right_end_value
);

	import cdq_pkg::*;

	localparam int IW = $clog2(RING_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FETCH = 1'b1;

	function automatic logic [IW-1:0] idx_up(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_down(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	// Sign-extend a stored value from its own width and keep the low 32 bits.
	function automatic logic [31:0] report(input logic [VALUE_WIDTH-1:0] v);
		logic signed [VALUE_WIDTH-1:0] sv;
		logic signed [63:0]            wide;
		sv   = signed'(v);
		wide = 64'(sv);
		return wide[31:0];
	endfunction

	logic                   state_q;
	logic                   done_q;
	logic                   empty_q;
	logic [IW-1:0]          left_idx_q;
	logic [IW-1:0]          right_idx_q;
	status_t                status_q;
	logic [31:0]            removed_q;
	logic [VALUE_WIDTH-1:0] left_val_q;
	logic [VALUE_WIDTH-1:0] right_val_q;
	logic                   fetch_left_q;

	logic                   accept;
	logic                   full;
	logic                   is_push;
	logic                   is_left;
	logic [63:0]            push_ext;
	logic [VALUE_WIDTH-1:0] push_data;

	logic                   nxt_state;
	logic                   nxt_done;
	logic                   nxt_empty;
	logic [IW-1:0]          nxt_left;
	logic [IW-1:0]          nxt_right;
	status_t                nxt_status;
	logic [31:0]            nxt_removed;
	logic [VALUE_WIDTH-1:0] nxt_left_val;
	logic [VALUE_WIDTH-1:0] nxt_right_val;

	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic                   ram_re;
	logic [IW-1:0]          ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	assign busy      = (state_q == ST_FETCH);
	assign accept    = start && !busy;
	assign full      = !empty_q && (idx_up(right_idx_q) == left_idx_q);
	assign is_push   = (kind == KIND_PUSH_LEFT) || (kind == KIND_PUSH_RIGHT);
	assign is_left   = (kind == KIND_PUSH_LEFT) || (kind == KIND_POP_LEFT);
	assign push_ext  = {32'b0, push_value};
	assign push_data = push_ext[VALUE_WIDTH-1:0];

	always_comb begin
		nxt_state     = state_q;
		nxt_done      = 1'b0;
		nxt_empty     = empty_q;
		nxt_left      = left_idx_q;
		nxt_right     = right_idx_q;
		nxt_status    = status_q;
		nxt_removed   = removed_q;
		nxt_left_val  = left_val_q;
		nxt_right_val = right_val_q;
		ram_we        = 1'b0;
		ram_waddr     = left_idx_q;
		ram_re        = 1'b0;
		ram_raddr     = left_idx_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					nxt_removed = '0;
					nxt_status  = STAT_DONE;
					if (is_push) begin
						nxt_done = 1'b1;
						if (full) begin
							nxt_status = STAT_OVERFLOW;
						end else if (empty_q) begin
							nxt_left      = '0;
							nxt_right     = '0;
							nxt_empty     = 1'b0;
							nxt_left_val  = push_data;
							nxt_right_val = push_data;
							ram_we        = 1'b1;
							ram_waddr     = '0;
						end else if (is_left) begin
							nxt_left     = idx_down(left_idx_q);
							nxt_left_val = push_data;
							ram_we       = 1'b1;
							ram_waddr    = idx_down(left_idx_q);
						end else begin
							nxt_right     = idx_up(right_idx_q);
							nxt_right_val = push_data;
							ram_we        = 1'b1;
							ram_waddr     = idx_up(right_idx_q);
						end
					end else begin
						if (empty_q) begin
							nxt_done   = 1'b1;
							nxt_status = STAT_UNDERFLOW;
						end else begin
							nxt_removed = is_left ? report(left_val_q) : report(right_val_q);
							if (left_idx_q == right_idx_q) begin
								nxt_done  = 1'b1;
								nxt_left  = '0;
								nxt_right = '0;
								nxt_empty = 1'b1;
							end else begin
								// The new end value is read from the ring and taken in ST_FETCH.
								nxt_state = ST_FETCH;
								ram_re    = 1'b1;
								if (is_left) begin
									nxt_left  = idx_up(left_idx_q);
									ram_raddr = idx_up(left_idx_q);
								end else begin
									nxt_right = idx_down(right_idx_q);
									ram_raddr = idx_down(right_idx_q);
								end
							end
						end
					end
				end
			end
			ST_FETCH: begin
				nxt_state = ST_IDLE;
				nxt_done  = 1'b1;
				if (fetch_left_q) begin
					nxt_left_val = ram_rdata;
				end else begin
					nxt_right_val = ram_rdata;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			empty_q     <= 1'b1;
			left_idx_q  <= '0;
			right_idx_q <= '0;
		end else begin
			state_q     <= nxt_state;
			done_q      <= nxt_done;
			empty_q     <= nxt_empty;
			left_idx_q  <= nxt_left;
			right_idx_q <= nxt_right;
		end
	end

	always_ff @(posedge clk) begin
		status_q    <= nxt_status;
		removed_q   <= nxt_removed;
		left_val_q  <= nxt_left_val;
		right_val_q <= nxt_right_val;
		if (accept) begin
			fetch_left_q <= is_left;
		end
	end

	cdq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (push_data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done            = done_q;
	assign status          = status_q;
	assign removed_value   = signed'(removed_q);
	assign is_empty        = empty_q;
	assign left_end_value  = empty_q ? '0 : signed'(report(left_val_q));
	assign right_end_value = empty_q ? '0 : signed'(report(right_val_q));

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (done_q && state_q == ST_IDLE))
		else $error("memory fetch did not complete in one cycle");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_push && empty_q) |=> (done_q && status_q == STAT_UNDERFLOW))
		else $error("pop from empty queue not reported as underflow");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (left_idx_q == '0 && right_idx_q == '0))
		else $error("empty queue with nonzero indices");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STAT_DONE) |-> (removed_q == '0))
		else $error("refused transaction reports a removed value");

endmodule

`default_nettype wire

[src/cdq_ram.sv]
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[tb/tb_circular_deque_unit.sv]
`timescale 1ns / 1ps

module tb_circular_deque_unit;
	import cdq_pkg::*;

	localparam int RING_DEPTH = 128;
	localparam int IDLE_LIMIT = 1000;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed;
		logic               empty;
		logic signed [31:0] left_end;
		logic signed [31:0] right_end;
	} deque_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	kind_t              kind;
	logic signed [31:0] push_value;
	logic               done;
	status_t            status;
	logic signed [31:0] removed_value;
	logic               is_empty;
	logic signed [31:0] left_end_value;
	logic signed [31:0] right_end_value;

	circular_deque_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.push_value      (push_value),
		.done            (done),
		.status          (status),
		.removed_value   (removed_value),
		.is_empty        (is_empty),
		.left_end_value  (left_end_value),
		.right_end_value (right_end_value)
	);

	// Shadow copy of the deque, advanced once per accepted transaction.
	logic signed [31:0] ring_copy [RING_DEPTH];
	int                 left_at;
	int                 right_at;
	bit                 ring_empty;
	int                 fill_level;
	int                 deepest_fill;

	deque_result_t      expected_results [$];
	int                 idle_pct;
	int                 commands_sent;
	int                 results_checked;
	int                 overflows_seen;
	int                 underflows_seen;
	int                 mismatches;
	int                 idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic deque_result_t predict_deque(kind_t op, logic signed [31:0] value);
		deque_result_t res;
		int            at;
		bit            full;
		res = '0;
		res.status = STAT_DONE;
		full = !ring_empty && ((right_at + 1) % RING_DEPTH) == left_at;
		if (op == KIND_PUSH_LEFT || op == KIND_PUSH_RIGHT) begin
			if (full) begin
				res.status = STAT_OVERFLOW;
				overflows_seen++;
			end else begin
				if (ring_empty) begin
					left_at = 0;
					right_at = 0;
					ring_empty = 1'b0;
					ring_copy[0] = value;
				end else if (op == KIND_PUSH_LEFT) begin
					left_at = (left_at + RING_DEPTH - 1) % RING_DEPTH;
					ring_copy[left_at] = value;
				end else begin
					right_at = (right_at + 1) % RING_DEPTH;
					ring_copy[right_at] = value;
				end
				fill_level++;
			end
		end else if (ring_empty) begin
			res.status = STAT_UNDERFLOW;
			underflows_seen++;
		end else begin
			at = (op == KIND_POP_LEFT) ? left_at : right_at;
			res.removed = ring_copy[at];
			if (left_at == right_at) begin
				left_at = 0;
				right_at = 0;
				ring_empty = 1'b1;
			end else if (op == KIND_POP_LEFT) begin
				left_at = (left_at + 1) % RING_DEPTH;
			end else begin
				right_at = (right_at + RING_DEPTH - 1) % RING_DEPTH;
			end
			fill_level--;
		end
		res.empty = ring_empty;
		if (!ring_empty) begin
			res.left_end = ring_copy[left_at];
			res.right_end = ring_copy[right_at];
		end
		return res;
	endfunction

	task automatic note_mismatch(string what, deque_result_t want, deque_result_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t %s: expected st=%0d rm=%h e=%b l=%h r=%h, got st=%0d rm=%h e=%b l=%h r=%h",
				$realtime, what, want.status, want.removed, want.empty, want.left_end,
				want.right_end, got.status, got.removed, got.empty, got.left_end,
				got.right_end);
		end
	endtask

	always @(posedge clk) begin : check_results
		deque_result_t got;
		deque_result_t want;
		if (arst_n && done) begin
			got.status = status;
			got.removed = removed_value;
			got.empty = is_empty;
			got.left_end = left_end_value;
			got.right_end = right_end_value;
			if (expected_results.size() == 0) begin
				note_mismatch("result with no transaction outstanding", '0, got);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got.status !== want.status || got.removed !== want.removed ||
						got.empty !== want.empty || got.left_end !== want.left_end ||
						got.right_end !== want.right_end) begin
					note_mismatch("result differs", want, got);
				end
			end
		end
	end

	// Ends a run that stops making progress in either direction.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("circular_deque_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_command(kind_t op, logic signed [31:0] value);
		start <= 1'b1;
		kind <= op;
		push_value <= value;
		do @(posedge clk); while (busy !== 1'b0);
		expected_results.push_back(predict_deque(op, value));
		commands_sent++;
		if (fill_level > deepest_fill) deepest_fill = fill_level;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic kind_t random_kind(int push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT;
		return $urandom_range(1) ? KIND_POP_RIGHT : KIND_POP_LEFT;
	endfunction

	task automatic test_directed();
		idle_pct = 0;
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_RIGHT, random_value());
		send_command(KIND_PUSH_LEFT, 32'sh8000_0000);
		send_command(KIND_POP_RIGHT, random_value());
		send_command(KIND_PUSH_RIGHT, 32'sh7fff_ffff);
		// A left push right after the first entry wraps the left index to the top.
		send_command(KIND_PUSH_LEFT, -32'sd1);
		send_command(KIND_PUSH_RIGHT, 32'sd0);
		send_command(KIND_PUSH_LEFT, 32'sh5555_5555);
		send_command(KIND_PUSH_RIGHT, 32'shaaaa_aaaa);
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_RIGHT, random_value());
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_RIGHT, random_value());
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_RIGHT, random_value());
		send_command(KIND_PUSH_RIGHT, 32'sd1);
		send_command(KIND_PUSH_RIGHT, 32'sh8000_0001);
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_LEFT, random_value());
		send_command(KIND_POP_LEFT, random_value());
	endtask

	task automatic test_full_ring();
		idle_pct = 14;
		while (fill_level < RING_DEPTH) begin
			send_command($urandom_range(1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT, random_value());
		end
		send_command(KIND_PUSH_LEFT, random_value());
		send_command(KIND_PUSH_RIGHT, random_value());
		idle_pct = 59;
		while (fill_level > 0) begin
			send_command(random_kind(0), random_value());
		end
		send_command(KIND_POP_RIGHT, random_value());
	endtask

	task automatic run_random_ops(int count, int push_pct);
		repeat (count) send_command(random_kind(push_pct), random_value());
	endtask

	// The receiver cannot hold results off, so only sender gaps vary by phase.
	task automatic test_random_mix();
		int gap_mix [3];
		gap_mix = '{0, 59, 14};
		foreach (gap_mix[i]) begin
			idle_pct = gap_mix[i];
			run_random_ops(25, 75);
			run_random_ops(25, 30);
			run_random_ops(10, 50);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_PUSH_LEFT;
		push_value = '0;
		left_at = 0;
		right_at = 0;
		ring_empty = 1'b1;
		fill_level = 0;
		deepest_fill = 0;
		idle_pct = 0;
		commands_sent = 0;
		results_checked = 0;
		overflows_seen = 0;
		underflows_seen = 0;
		mismatches = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_for_results();
		test_full_ring();
		wait_for_results();
		test_random_mix();
		wait_for_results();
		repeat (4) @(posedge clk);

		$display("Sent %0d commands, checked %0d results (%0d overflows, %0d underflows).",
			commands_sent, results_checked, overflows_seen, underflows_seen);
		$display("Queue filled up to %0d of %0d entries under no, 59%% and 14%% sender gaps.",
			deepest_fill, RING_DEPTH);
		if (mismatches == 0) begin
			$display("circular_deque_unit: match");
		end else begin
			$display("circular_deque_unit: mismatch");
		end
		$finish;
	end

endmodule

[files.f]
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque_unit.sv
tb/tb_circular_deque_unit.sv
